// ===== rtl/core/sha256_pkg.sv =====
`timescale 1ns / 1ps

package sha256_pkg;

    typedef logic [31:0] word_t;

    // Pad sequencer phases for the final block(s) of a message.
    typedef logic [1:0] pad_phase_t;
    localparam pad_phase_t PAD_NONE    = 2'd0;
    localparam pad_phase_t PAD_FILL    = 2'd1;
    localparam pad_phase_t PAD_LEN_HI  = 2'd2;
    localparam pad_phase_t PAD_LEN_LO  = 2'd3;

    localparam word_t MARKER_WORD = 32'h8000_0000;

    // Initial hash value, word 0 first.
    function automatic word_t init_vec(input logic [2:0] idx);
        word_t r;
        unique case (idx)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            3'd7: r = 32'h5be0cd19;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

    // Round constants.
    function automatic word_t round_const(input logic [5:0] idx);
        word_t r;
        unique case (idx)
            6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
            6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
            6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
            6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
            6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
            6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
            6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
            6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
            6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
            6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
            6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
            6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
            6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
            6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
            6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
            6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
            6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
            6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
            6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
            6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
            6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
            6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
            6'd62: r = 32'hbef9a3f7;  6'd63: r = 32'hc67178f2;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

    // Sigma functions of the compression round and the message schedule.
    function automatic word_t big_sigma0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

// ===== rtl/core/sha256_message_hash_unit.sv =====
`timescale 1ns / 1ps

// SHA-256 hasher that takes a message as big-endian 32-bit words, one beat
// per word, and returns the eight digest words (word 0 first) after the beat
// flagged end_of_message; it then starts over on a fresh message. A single
// round unit runs one compression round per cycle: a block takes its sixteen
// word beats, the 64 rounds and a fold of the result into the hash. The
// final word is followed by the padding and length words still to be placed
// (up to 17 of them, plus a second compression when the length does not
// fit), and then the eight digest words are read out.
// s_ready is high only while the sequencer waits for input; a digest word
// still waiting in the output register does not hold up the next message.
module sha256_message_hash_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_data_word,
    input  logic [2:0]  s_byte_count,
    input  logic        s_end_of_message,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_digest_word
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PAD    = 3'd1;
    localparam logic [2:0] ST_ROUND  = 3'd2;
    localparam logic [2:0] ST_UPDATE = 3'd3;
    localparam logic [2:0] ST_OUT    = 3'd4;

    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [3:0] LEN_HI_POS = 4'd14;
    localparam logic [3:0] LAST_POS   = 4'd15;
    localparam logic [2:0] LAST_IDX   = 3'd7;

    logic [2:0]                   state_reg, state_next;
    logic [3:0]                   wpos_reg, wpos_next;
    logic [5:0]                   round_reg, round_next;
    logic [63:0]                  bit_len_reg, bit_len_next;
    sha256_pkg::pad_phase_t       phase_reg, phase_next;
    logic                         marker_reg, marker_next;
    logic [2:0]                   out_idx_reg, out_idx_next;

    sha256_pkg::word_t            hash_reg [8];
    sha256_pkg::word_t            v_reg [8];
    sha256_pkg::word_t            win_reg [16];

    logic                         m_valid_reg, m_valid_next;
    sha256_pkg::word_t            m_word_reg;
    logic [2:0]                   m_idx_reg;
    logic                         m_last_reg;

    logic                         s_fire;
    logic [2:0]                   cnt_sat;
    logic                         cnt_full;
    sha256_pkg::word_t            keep_mask;
    sha256_pkg::word_t            first_pad_word;
    logic                         push;
    sha256_pkg::word_t            push_word;
    logic                         push_wraps;
    logic                         out_load;

    sha256_pkg::word_t            t1, t2, sched_word;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;

    // Final-word byte handling: saturate the count, mask, add the marker byte.
    assign cnt_sat   = (s_byte_count > 3'd4) ? 3'd4 : s_byte_count;
    assign cnt_full  = cnt_sat[2];
    assign keep_mask = ~(32'hffff_ffff >> {cnt_sat[1:0], 3'b000});
    assign first_pad_word = (s_data_word & keep_mask)
                          | (sha256_pkg::MARKER_WORD >> {cnt_sat[1:0], 3'b000});

    // Word to shift into the schedule window this cycle, if any.
    always_comb begin
        push      = 1'b0;
        push_word = '0;
        if (state_reg == ST_IDLE) begin
            push = s_valid;
            if (s_end_of_message && !cnt_full) begin
                push_word = first_pad_word;
            end else begin
                push_word = s_data_word;
            end
        end else if (state_reg == ST_PAD) begin
            push = 1'b1;
            priority if (marker_reg) begin
                push_word = sha256_pkg::MARKER_WORD;
            end else if (phase_reg == sha256_pkg::PAD_FILL && wpos_reg == LEN_HI_POS) begin
                push_word = bit_len_reg[63:32];
            end else if (phase_reg == sha256_pkg::PAD_LEN_HI) begin
                push_word = bit_len_reg[31:0];
            end else begin
                push_word = '0;
            end
        end
    end

    assign push_wraps = push && (wpos_reg == LAST_POS);

    // Round datapath: compression round and next schedule word.
    always_comb begin
        t1 = v_reg[7] + sha256_pkg::big_sigma1(v_reg[4])
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + sha256_pkg::round_const(round_reg) + win_reg[0];
        t2 = sha256_pkg::big_sigma0(v_reg[0])
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        sched_word = sha256_pkg::small_sigma1(win_reg[14]) + win_reg[9]
                   + sha256_pkg::small_sigma0(win_reg[1]) + win_reg[0];
    end

    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    // Sequencer.
    always_comb begin
        state_next   = state_reg;
        wpos_next    = wpos_reg;
        round_next   = round_reg;
        bit_len_next = bit_len_reg;
        phase_next   = phase_reg;
        marker_next  = marker_reg;
        out_idx_next = out_idx_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_end_of_message) begin
                        bit_len_next = bit_len_reg + {58'd0, cnt_sat, 3'b000};
                        phase_next   = sha256_pkg::PAD_FILL;
                        marker_next  = cnt_full;
                        state_next   = ST_PAD;
                    end else begin
                        bit_len_next = bit_len_reg + 64'd32;
                    end
                end
            end
            ST_PAD: begin
                if (marker_reg) begin
                    marker_next = 1'b0;
                end else if (phase_reg == sha256_pkg::PAD_FILL && wpos_reg == LEN_HI_POS) begin
                    phase_next = sha256_pkg::PAD_LEN_HI;
                end else if (phase_reg == sha256_pkg::PAD_LEN_HI) begin
                    phase_next = sha256_pkg::PAD_LEN_LO;
                end
            end
            ST_ROUND: begin
                round_next = round_reg + 6'd1;
                if (round_reg == LAST_ROUND) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                unique case (phase_reg)
                    sha256_pkg::PAD_NONE:   state_next = ST_IDLE;
                    sha256_pkg::PAD_LEN_LO: state_next = ST_OUT;
                    default:                state_next = ST_PAD;
                endcase
            end
            ST_OUT: begin
                if (out_load) begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (out_idx_reg == LAST_IDX) begin
                        state_next   = ST_IDLE;
                        bit_len_next = '0;
                        phase_next   = sha256_pkg::PAD_NONE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // A full window starts a compression from either input state.
        if (push) begin
            wpos_next = wpos_reg + 4'd1;
            if (push_wraps) begin
                round_next = '0;
                state_next = ST_ROUND;
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wpos_reg    <= '0;
            round_reg   <= '0;
            bit_len_reg <= '0;
            phase_reg   <= sha256_pkg::PAD_NONE;
            marker_reg  <= 1'b0;
            out_idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wpos_reg    <= wpos_next;
            round_reg   <= round_next;
            bit_len_reg <= bit_len_next;
            phase_reg   <= phase_next;
            marker_reg  <= marker_next;
            out_idx_reg <= out_idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Schedule window: words shift in at the top, rounds read the bottom.
    always_ff @(posedge aclk) begin
        if (push || state_reg == ST_ROUND) begin
            for (int j = 0; j < 15; j++) begin
                win_reg[j] <= win_reg[j + 1];
            end
            win_reg[15] <= push ? push_word : sched_word;
        end
    end

    // Working variables a..h.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < 8; j++) begin
                v_reg[j] <= '0;
            end
        end else if (push_wraps) begin
            for (int j = 0; j < 8; j++) begin
                v_reg[j] <= hash_reg[j];
            end
        end else if (state_reg == ST_ROUND) begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    // Running hash: fold in after each block, reload after the digest leaves.
    always_ff @(posedge aclk) begin
        if (!aresetn || (out_load && out_idx_reg == LAST_IDX)) begin
            for (int j = 0; j < 8; j++) begin
                hash_reg[j] <= sha256_pkg::init_vec(3'(j));
            end
        end else if (state_reg == ST_UPDATE) begin
            for (int j = 0; j < 8; j++) begin
                hash_reg[j] <= hash_reg[j] + v_reg[j];
            end
        end
    end

    // Output register for digest beats.
    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_word_reg <= hash_reg[out_idx_reg];
            m_idx_reg  <= out_idx_reg;
            m_last_reg <= (out_idx_reg == LAST_IDX);
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_digest_word      = m_word_reg;
    assign m_word_index       = m_idx_reg;
    assign m_last_digest_word = m_last_reg;

    // The round sequence always ends in a hash update.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && round_reg == LAST_ROUND) |=> (state_reg == ST_UPDATE))
        else $error("round sequence did not end in hash update");

    // Padding only runs while a pad phase is open and the length is not done.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PAD) |-> (phase_reg != sha256_pkg::PAD_NONE
                                   && phase_reg != sha256_pkg::PAD_LEN_LO))
        else $error("pad sequencer in an impossible phase");

    // The length low word is always the last word of a block.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && state_reg == ST_PAD && phase_reg == sha256_pkg::PAD_LEN_HI)
        |-> (wpos_reg == LAST_POS))
        else $error("length word misplaced in final block");

    // The last flag marks exactly the eighth digest word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_last_reg == (m_idx_reg == LAST_IDX)))
        else $error("last flag does not match digest word index");

endmodule
